### src/i2cm_pkg.sv
// Shared types and constants for the I2C master bit sequencer.
package i2cm_pkg;

	localparam logic [15:0] PHASE_DELAY_RST = 16'd200;
	localparam logic [7:0]  ACK_TIMEOUT_RST = 8'd250;

	// configuration register indexes
	typedef enum logic {
		CFG_PHASE_DELAY = 1'b0,
		CFG_ACK_TIMEOUT = 1'b1
	} cfg_idx_t;

	typedef enum logic [2:0] {
		OP_START     = 3'd0,
		OP_STOP      = 3'd1,
		OP_WRITE     = 3'd2,
		OP_WAIT_ACK  = 3'd3,
		OP_READ      = 3'd4,
		OP_ACK_ONLY  = 3'd5
	} opcode_t;

	typedef enum logic [14:0] {
		PH_IDLE     = 15'h0001,
		PH_START_HI = 15'h0002,
		PH_START_LO = 15'h0004,
		PH_STOP_LO  = 15'h0008,
		PH_STOP_HI  = 15'h0010,
		PH_WR_SETUP = 15'h0020,
		PH_WR_HIGH  = 15'h0040,
		PH_WR_LOW   = 15'h0080,
		PH_ACK_REL  = 15'h0100,
		PH_ACK_HIGH = 15'h0200,
		PH_ACK_POLL = 15'h0400,
		PH_RD_LOW   = 15'h0800,
		PH_RD_HIGH  = 15'h1000,
		PH_AK_LO    = 15'h2000,
		PH_AK_HI    = 15'h4000
	} phase_t;

	typedef struct packed {
		logic       sda_sample;
		logic       send_ack;
		logic [7:0] write_data;
		logic [2:0] opcode;
		logic       cmd_valid;
	} item_t;

	typedef struct packed {
		logic       ack_missing;
		logic [7:0] read_data;
		logic       done_res;
		logic       busy_res;
		logic       sda_drive_enable;
		logic       sda_level;
		logic       scl_level;
	} res_t;

endpackage

### src/i2cm_seq.sv
// Bus phase sequencer: state registers and the per-tick next-state logic.
module i2cm_seq (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,
	input  i2cm_pkg::item_t    item,
	input  logic [15:0]        phase_delay,
	input  logic [7:0]         ack_timeout,
	output i2cm_pkg::res_t     res
);

	i2cm_pkg::phase_t ph_q, ph_d;
	logic [15:0] dc_q, dc_d, dc_inc, dly;
	logic [7:0]  tc_q, tc_d;
	logic [3:0]  bc_q, bc_d, bc_inc;
	logic [7:0]  sr_q, sr_d;
	logic [7:0]  rd_q, rd_d;
	logic        scl_q, scl_d, sda_q, sda_d, drv_q, drv_d;
	logic        ack_q, ack_d, miss_q, miss_d;
	logic        done_c;

	always_comb begin
		ph_d   = ph_q;
		dc_d   = dc_q;
		tc_d   = tc_q;
		bc_d   = bc_q;
		sr_d   = sr_q;
		rd_d   = rd_q;
		scl_d  = scl_q;
		sda_d  = sda_q;
		drv_d  = drv_q;
		ack_d  = ack_q;
		miss_d = miss_q;
		done_c = 1'b0;
		dc_inc = dc_q + 16'd1;
		bc_inc = bc_q + 4'd1;
		dly    = (phase_delay == 16'd0) ? 16'd1 : phase_delay;

		if (ph_q == i2cm_pkg::PH_IDLE) begin
			if (item.cmd_valid) begin
				ack_d = item.send_ack;
				unique case (item.opcode)
					i2cm_pkg::OP_START: begin
						{scl_d, sda_d, drv_d} = 3'b111;
						ph_d = i2cm_pkg::PH_START_HI;
						dc_d = '0;
					end
					i2cm_pkg::OP_STOP: begin
						{scl_d, sda_d, drv_d} = 3'b001;
						ph_d = i2cm_pkg::PH_STOP_LO;
						dc_d = '0;
					end
					i2cm_pkg::OP_WRITE: begin
						sr_d = item.write_data;
						bc_d = '0;
						{scl_d, sda_d, drv_d} = {1'b0, item.write_data[7], 1'b1};
						ph_d = i2cm_pkg::PH_WR_SETUP;
						dc_d = '0;
					end
					i2cm_pkg::OP_WAIT_ACK: begin
						miss_d = 1'b0;
						tc_d   = '0;
						{sda_d, drv_d} = 2'b10;
						ph_d = i2cm_pkg::PH_ACK_REL;
						dc_d = '0;
					end
					i2cm_pkg::OP_READ: begin
						sr_d = '0;
						bc_d = '0;
						{scl_d, sda_d, drv_d} = 3'b010;
						ph_d = i2cm_pkg::PH_RD_LOW;
						dc_d = '0;
					end
					i2cm_pkg::OP_ACK_ONLY: begin
						{scl_d, sda_d, drv_d} = {1'b0, ~item.send_ack, 1'b1};
						ph_d = i2cm_pkg::PH_AK_LO;
						dc_d = '0;
					end
					default: begin
						ph_d = i2cm_pkg::PH_IDLE;
					end
				endcase
			end
		end else if (ph_q == i2cm_pkg::PH_ACK_POLL) begin
			if (!item.sda_sample) begin
				scl_d  = 1'b0;
				ph_d   = i2cm_pkg::PH_IDLE;
				dc_d   = '0;
				done_c = 1'b1;
			end else if (tc_q >= ack_timeout) begin
				miss_d = 1'b1;
				{scl_d, sda_d, drv_d} = 3'b001;
				ph_d = i2cm_pkg::PH_STOP_LO;
				dc_d = '0;
			end else begin
				tc_d = tc_q + 8'd1;
			end
		end else begin
			dc_d = dc_inc;
			if (dc_inc >= dly) begin
				// every phase that expires moves on to another phase
				dc_d = '0;
				unique case (ph_q)
					i2cm_pkg::PH_START_HI: begin
						{scl_d, sda_d, drv_d} = 3'b101;
						ph_d = i2cm_pkg::PH_START_LO;
					end
					i2cm_pkg::PH_START_LO: begin
						{scl_d, sda_d, drv_d} = 3'b001;
						ph_d   = i2cm_pkg::PH_IDLE;
						done_c = 1'b1;
					end
					i2cm_pkg::PH_STOP_LO: begin
						{scl_d, sda_d, drv_d} = 3'b101;
						ph_d = i2cm_pkg::PH_STOP_HI;
					end
					i2cm_pkg::PH_STOP_HI: begin
						{scl_d, sda_d, drv_d} = 3'b111;
						ph_d   = i2cm_pkg::PH_IDLE;
						done_c = 1'b1;
					end
					i2cm_pkg::PH_WR_SETUP: begin
						{scl_d, drv_d} = 2'b11;
						ph_d = i2cm_pkg::PH_WR_HIGH;
					end
					i2cm_pkg::PH_WR_HIGH: begin
						{scl_d, drv_d} = 2'b01;
						ph_d = i2cm_pkg::PH_WR_LOW;
					end
					i2cm_pkg::PH_WR_LOW: begin
						bc_d = bc_inc;
						if (bc_inc[3]) begin
							ph_d   = i2cm_pkg::PH_IDLE;
							done_c = 1'b1;
						end else begin
							// bit 7 - n of the byte, MSB first
							{scl_d, sda_d, drv_d} = {1'b0, sr_q[~bc_inc[2:0]], 1'b1};
							ph_d = i2cm_pkg::PH_WR_SETUP;
						end
					end
					i2cm_pkg::PH_ACK_REL: begin
						{scl_d, sda_d, drv_d} = 3'b110;
						ph_d = i2cm_pkg::PH_ACK_HIGH;
					end
					i2cm_pkg::PH_ACK_HIGH: begin
						tc_d = '0;
						ph_d = i2cm_pkg::PH_ACK_POLL;
					end
					i2cm_pkg::PH_RD_LOW: begin
						{scl_d, sda_d, drv_d} = 3'b110;
						sr_d = {sr_q[6:0], item.sda_sample};
						ph_d = i2cm_pkg::PH_RD_HIGH;
					end
					i2cm_pkg::PH_RD_HIGH: begin
						bc_d = bc_inc;
						if (bc_inc[3]) begin
							rd_d = sr_q;
							{scl_d, sda_d, drv_d} = {1'b0, ~ack_q, 1'b1};
							ph_d = i2cm_pkg::PH_AK_LO;
						end else begin
							{scl_d, sda_d, drv_d} = 3'b010;
							ph_d = i2cm_pkg::PH_RD_LOW;
						end
					end
					i2cm_pkg::PH_AK_LO: begin
						{scl_d, drv_d} = 2'b11;
						ph_d = i2cm_pkg::PH_AK_HI;
					end
					i2cm_pkg::PH_AK_HI: begin
						{scl_d, drv_d} = 2'b01;
						ph_d   = i2cm_pkg::PH_IDLE;
						done_c = 1'b1;
					end
					default: begin
						ph_d = i2cm_pkg::PH_IDLE;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q   <= i2cm_pkg::PH_IDLE;
			dc_q   <= '0;
			tc_q   <= '0;
			bc_q   <= '0;
			sr_q   <= '0;
			rd_q   <= '0;
			scl_q  <= 1'b1;
			sda_q  <= 1'b1;
			drv_q  <= 1'b1;
			ack_q  <= 1'b0;
			miss_q <= 1'b0;
		end else if (step) begin
			ph_q   <= ph_d;
			dc_q   <= dc_d;
			tc_q   <= tc_d;
			bc_q   <= bc_d;
			sr_q   <= sr_d;
			rd_q   <= rd_d;
			scl_q  <= scl_d;
			sda_q  <= sda_d;
			drv_q  <= drv_d;
			ack_q  <= ack_d;
			miss_q <= miss_d;
		end
	end

	always_comb begin
		res.scl_level        = scl_d;
		res.sda_level        = sda_d | ~drv_d;
		res.sda_drive_enable = drv_d;
		res.busy_res         = (ph_d != i2cm_pkg::PH_IDLE);
		res.done_res         = done_c;
		res.read_data        = rd_d;
		res.ack_missing      = miss_d;
	end

`ifndef SYNTH
	a_done_goes_idle: assert property (@(posedge clk) disable iff (!arst_n)
		step && done_c |=> ph_q == i2cm_pkg::PH_IDLE)
		else $error("done pulse without return to idle");

	a_miss_from_poll: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(miss_q) |-> $past(ph_q) == i2cm_pkg::PH_ACK_POLL
			&& ph_q == i2cm_pkg::PH_STOP_LO)
		else $error("ack missing flag set outside ack polling");

	a_bit_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		bc_q <= 4'd8)
		else $error("bit counter past one byte");

	a_read_byte_hold: assert property (@(posedge clk) disable iff (!arst_n)
		$past(ph_q) != i2cm_pkg::PH_RD_HIGH |-> $stable(rd_q))
		else $error("read byte changed outside the last read bit");
`endif

endmodule

### src/i2c_master_bit_sequencer_top.sv
// Top level of the I2C master bit sequencer: stream ports, config registers, pipeline.
// A tick transferred in passes through the input register, then the result register,
// and is held there longer while the result side stalls.
// Throughput: one tick per cycle while the result side does not stall; the next-state logic
// of the phase sequencer is combinational and sits between the input register and the result register.
// Reset (arst_n, asynchronous, active low): sequencer idle, SCL high, SDA driven high,
// phase delay 200 ticks, ack timeout 250 ticks, read byte and ack missing flag cleared.
module i2c_master_bit_sequencer_top (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        s_tvalid,
	output logic        s_tready,
	// [7:0] write_data, [8] send_ack, [9] sda_sample, [15:10] zero
	input  logic [15:0] s_tdata,
	// [0] cmd_valid, [3:1] opcode
	input  logic [3:0]  s_tuser,

	output logic        m_tvalid,
	input  logic        m_tready,
	// [0] scl_level, [1] sda_level, [2] sda_drive_enable, [3] busy_res,
	// [4] done_res, [12:5] read_data, [13] ack_missing, [15:14] zero
	output logic [15:0] m_tdata,

	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [15:0] cfg_wdata
);

	logic [15:0]     phase_delay_q;
	logic [7:0]      ack_timeout_q;

	logic            valid_s1;
	i2cm_pkg::item_t item_s1;
	logic            valid_s2;
	i2cm_pkg::res_t  res_s2;
	i2cm_pkg::res_t  res_next;
	logic            advance;

	// The user must make config writes only while the sequencer is idle (unenforced); no handshake.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_delay_q <= i2cm_pkg::PHASE_DELAY_RST;
			ack_timeout_q <= i2cm_pkg::ACK_TIMEOUT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				i2cm_pkg::CFG_PHASE_DELAY: phase_delay_q <= cfg_wdata;
				i2cm_pkg::CFG_ACK_TIMEOUT: ack_timeout_q <= cfg_wdata[7:0];
				default: ;
			endcase
		end
	end

	// Advance the held tick into the sequencer when the result slot is free or drains.
	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	// Take a new tick whenever the input register is empty or empties this cycle.
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	// Hold the payload of a stalled tick; capture on every input transfer.
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.cmd_valid  <= s_tuser[0];
			item_s1.opcode     <= s_tuser[3:1];
			item_s1.write_data <= s_tdata[7:0];
			item_s1.send_ack   <= s_tdata[8];
			item_s1.sda_sample <= s_tdata[9];
		end
	end

	i2cm_seq u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (advance),
		.item        (item_s1),
		.phase_delay (phase_delay_q),
		.ack_timeout (ack_timeout_q),
		.res         (res_next)
	);

	// Result register: drop the flag once the transfer completes, refill on advance.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res_next;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {2'b00, res_s2.ack_missing, res_s2.read_data, res_s2.done_res,
		res_s2.busy_res, res_s2.sda_drive_enable, res_s2.sda_level, res_s2.scl_level};

endmodule

### dv/tb.sv
// Testbench for the I2C master bit sequencer: stream driver, monitor and per-tick line predictor.
`timescale 1ns / 1ps

module tb;

	// opcodes outside the command set, which the sequencer must ignore
	localparam logic [2:0]  OP_RSVD_6 = 3'd6;
	localparam logic [2:0]  OP_RSVD_7 = 3'd7;
	localparam logic [15:0] ACK_TIMEOUT_MAX = 16'd255;
	localparam int          ACK_NEVER = -1;
	localparam int          SDA_FREE = -1;
	localparam int          QUEUE_DEPTH = 32;
	localparam int          LONG_HOLD = 300;
	localparam int          RANDOM_TICKS = 100;
	localparam int          RETUNE_EVERY = 40;

	// sequencer state as the predictor tracks it, registers included
	typedef struct {
		logic [15:0]      delay_cfg;
		logic [7:0]       timeout_cfg;
		i2cm_pkg::phase_t phase;
		logic [2:0]       cmd;
		logic [3:0]       nbits;
		logic [7:0]       shreg;
		logic [15:0]      dcnt;
		logic [7:0]       tcnt;
		logic             scl;
		logic             sda;
		logic             drv;
		logic             ack_sel;
		logic [7:0]       rd_byte;
		logic             missing;
	} seq_model_t;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = '0;
	logic [3:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;
	logic        cfg_we = 1'b0;
	logic        cfg_index = 1'b0;
	logic [15:0] cfg_wdata = '0;

	i2cm_pkg::item_t ticks_to_send[$];
	i2cm_pkg::res_t  line_states_due[$];
	seq_model_t      plan_seq;	// state after every tick queued so far
	seq_model_t      live_seq;	// state after every tick transferred so far
	i2cm_pkg::item_t on_bus;

	int n_errors = 0;
	int n_items = 0;
	int src_gap_left = 0;
	int sink_stall_left = 0;
	int hold_left = 0;
	int hold_reqs = 0;
	int hold_served = 0;
	bit src_gap_on = 1'b0;
	bit sink_stall_on = 1'b0;
	int ack_delay = ACK_NEVER;
	int polls = 0;
	int sda_force = SDA_FREE;

	i2c_master_bit_sequencer_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// hard stop in case the handshakes hang
	initial begin
		#2_000_000;
		$display("FAILURE");
		$finish;
	end

	function automatic seq_model_t fresh_model();
		seq_model_t m;
		m.delay_cfg = i2cm_pkg::PHASE_DELAY_RST;
		m.timeout_cfg = i2cm_pkg::ACK_TIMEOUT_RST;
		m.phase = i2cm_pkg::PH_IDLE;
		m.cmd = '0;
		m.nbits = '0;
		m.shreg = '0;
		m.dcnt = '0;
		m.tcnt = '0;
		m.scl = 1'b1;
		m.sda = 1'b1;
		m.drv = 1'b1;
		m.ack_sel = 1'b0;
		m.rd_byte = '0;
		m.missing = 1'b0;
		return m;
	endfunction

	function automatic void set_cfg(inout seq_model_t m, input i2cm_pkg::cfg_idx_t idx,
			input logic [15:0] v);
		case (idx)
			i2cm_pkg::CFG_PHASE_DELAY: m.delay_cfg = v;
			i2cm_pkg::CFG_ACK_TIMEOUT: m.timeout_cfg = v[7:0];
		endcase
	endfunction

	// Advance the sequencer by one tick and return the line levels it shows.
	function automatic i2cm_pkg::res_t bus_tick(inout seq_model_t m,
			input i2cm_pkg::item_t it);
		i2cm_pkg::res_t r;
		logic           done;
		logic [15:0]    span;
		done = 1'b0;
		// a zero phase delay still lasts one tick
		span = (m.delay_cfg == 16'd0) ? 16'd1 : m.delay_cfg;
		if (m.phase == i2cm_pkg::PH_IDLE) begin
			// commands land only while idle; reserved opcodes leave it idle
			if (it.cmd_valid) begin
				m.cmd = it.opcode;
				m.ack_sel = it.send_ack;
				m.dcnt = '0;
				case (it.opcode)
					i2cm_pkg::OP_START: begin
						{m.scl, m.sda, m.drv} = 3'b111;
						m.phase = i2cm_pkg::PH_START_HI;
					end
					i2cm_pkg::OP_STOP: begin
						{m.scl, m.sda, m.drv} = 3'b001;
						m.phase = i2cm_pkg::PH_STOP_LO;
					end
					i2cm_pkg::OP_WRITE: begin
						m.shreg = it.write_data;
						m.nbits = '0;
						{m.scl, m.sda, m.drv} = {1'b0, it.write_data[7], 1'b1};
						m.phase = i2cm_pkg::PH_WR_SETUP;
					end
					i2cm_pkg::OP_WAIT_ACK: begin
						// keep SCL where it is, release SDA
						m.missing = 1'b0;
						m.tcnt = '0;
						m.sda = 1'b1;
						m.drv = 1'b0;
						m.phase = i2cm_pkg::PH_ACK_REL;
					end
					i2cm_pkg::OP_READ: begin
						m.shreg = '0;
						m.nbits = '0;
						{m.scl, m.sda, m.drv} = 3'b010;
						m.phase = i2cm_pkg::PH_RD_LOW;
					end
					i2cm_pkg::OP_ACK_ONLY: begin
						{m.scl, m.sda, m.drv} = {1'b0, ~it.send_ack, 1'b1};
						m.phase = i2cm_pkg::PH_AK_LO;
					end
					default: ;
				endcase
			end
		end else if (m.phase == i2cm_pkg::PH_ACK_POLL) begin
			// poll every tick: low SDA is the ack, too many high ticks force a stop
			if (!it.sda_sample) begin
				m.scl = 1'b0;
				m.phase = i2cm_pkg::PH_IDLE;
				m.dcnt = '0;
				done = 1'b1;
			end else if (m.tcnt >= m.timeout_cfg) begin
				m.missing = 1'b1;
				{m.scl, m.sda, m.drv} = 3'b001;
				m.phase = i2cm_pkg::PH_STOP_LO;
				m.dcnt = '0;
			end else begin
				m.tcnt = m.tcnt + 8'd1;
			end
		end else begin
			m.dcnt = m.dcnt + 16'd1;
			if (m.dcnt >= span) begin
				m.dcnt = '0;
				case (m.phase)
					i2cm_pkg::PH_START_HI: begin
						{m.scl, m.sda, m.drv} = 3'b101;
						m.phase = i2cm_pkg::PH_START_LO;
					end
					i2cm_pkg::PH_START_LO: begin
						{m.scl, m.sda, m.drv} = 3'b001;
						m.phase = i2cm_pkg::PH_IDLE;
						done = 1'b1;
					end
					i2cm_pkg::PH_STOP_LO: begin
						{m.scl, m.sda, m.drv} = 3'b101;
						m.phase = i2cm_pkg::PH_STOP_HI;
					end
					i2cm_pkg::PH_STOP_HI: begin
						{m.scl, m.sda, m.drv} = 3'b111;
						m.phase = i2cm_pkg::PH_IDLE;
						done = 1'b1;
					end
					i2cm_pkg::PH_WR_SETUP: begin
						m.scl = 1'b1;
						m.drv = 1'b1;
						m.phase = i2cm_pkg::PH_WR_HIGH;
					end
					i2cm_pkg::PH_WR_HIGH: begin
						m.scl = 1'b0;
						m.drv = 1'b1;
						m.phase = i2cm_pkg::PH_WR_LOW;
					end
					i2cm_pkg::PH_WR_LOW: begin
						m.nbits = m.nbits + 4'd1;
						if (m.nbits >= 4'd8) begin
							m.phase = i2cm_pkg::PH_IDLE;
							done = 1'b1;
						end else begin
							{m.scl, m.sda, m.drv} = {1'b0, m.shreg[3'd7 - m.nbits[2:0]], 1'b1};
							m.phase = i2cm_pkg::PH_WR_SETUP;
						end
					end
					i2cm_pkg::PH_ACK_REL: begin
						{m.scl, m.sda, m.drv} = 3'b110;
						m.phase = i2cm_pkg::PH_ACK_HIGH;
					end
					i2cm_pkg::PH_ACK_HIGH: begin
						m.tcnt = '0;
						m.phase = i2cm_pkg::PH_ACK_POLL;
					end
					i2cm_pkg::PH_RD_LOW: begin
						// sample the bit as SCL goes high
						{m.scl, m.sda, m.drv} = 3'b110;
						m.shreg = {m.shreg[6:0], it.sda_sample};
						m.phase = i2cm_pkg::PH_RD_HIGH;
					end
					i2cm_pkg::PH_RD_HIGH: begin
						m.nbits = m.nbits + 4'd1;
						if (m.nbits >= 4'd8) begin
							m.rd_byte = m.shreg;
							{m.scl, m.sda, m.drv} = {1'b0, ~m.ack_sel, 1'b1};
							m.phase = i2cm_pkg::PH_AK_LO;
						end else begin
							{m.scl, m.sda, m.drv} = 3'b010;
							m.phase = i2cm_pkg::PH_RD_LOW;
						end
					end
					i2cm_pkg::PH_AK_LO: begin
						m.scl = 1'b1;
						m.drv = 1'b1;
						m.phase = i2cm_pkg::PH_AK_HI;
					end
					i2cm_pkg::PH_AK_HI: begin
						m.scl = 1'b0;
						m.drv = 1'b1;
						m.phase = i2cm_pkg::PH_IDLE;
						done = 1'b1;
					end
					default: m.phase = i2cm_pkg::PH_IDLE;
				endcase
			end
		end
		r.scl_level = m.scl;
		r.sda_level = m.sda | ~m.drv;
		r.sda_drive_enable = m.drv;
		r.busy_res = (m.phase != i2cm_pkg::PH_IDLE);
		r.done_res = done;
		r.read_data = m.rd_byte;
		r.ack_missing = m.missing;
		return r;
	endfunction

	function automatic int pick_src_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (!src_gap_on || roll < 70)
			return 0;
		if (roll < 95)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic int pick_sink_stall();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 75)
			return 0;
		if (roll < 97)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Print one line per mismatch (the first 20 only) and count it.
	task automatic report_mismatch(input string what, input int got, input int want);
		n_errors++;
		if (n_errors <= 20)
			$display("mismatch in %s: got %0d, want %0d at %0t", what, got, want, $time);
	endtask

	// Compare one transferred result with the oldest predicted line state.
	task automatic check_lines(input i2cm_pkg::res_t got);
		i2cm_pkg::res_t want;
		if (line_states_due.size() == 0) begin
			report_mismatch("unexpected result", int'(got), 0);
			return;
		end
		want = line_states_due.pop_front();
		if (got.scl_level !== want.scl_level)
			report_mismatch("scl_level", int'(got.scl_level), int'(want.scl_level));
		if (got.sda_level !== want.sda_level)
			report_mismatch("sda_level", int'(got.sda_level), int'(want.sda_level));
		if (got.sda_drive_enable !== want.sda_drive_enable)
			report_mismatch("sda_drive_enable", int'(got.sda_drive_enable),
				int'(want.sda_drive_enable));
		if (got.busy_res !== want.busy_res)
			report_mismatch("busy_res", int'(got.busy_res), int'(want.busy_res));
		if (got.done_res !== want.done_res)
			report_mismatch("done_res", int'(got.done_res), int'(want.done_res));
		if (got.read_data !== want.read_data)
			report_mismatch("read_data", int'(got.read_data), int'(want.read_data));
		if (got.ack_missing !== want.ack_missing)
			report_mismatch("ack_missing", int'(got.ack_missing), int'(want.ack_missing));
	endtask

	// Driver: predict on each input transfer, then offer the next queued tick,
	// possibly after a random gap.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready)
				line_states_due.push_back(bus_tick(live_seq, on_bus));
			if (!s_tvalid || s_tready) begin
				if (src_gap_left > 0) begin
					src_gap_left--;
					s_tvalid <= 1'b0;
				end else if (ticks_to_send.size() != 0) begin
					on_bus = ticks_to_send.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= {6'b0, on_bus.sda_sample, on_bus.send_ack, on_bus.write_data};
					s_tuser <= {on_bus.opcode, on_bus.cmd_valid};
					src_gap_left = pick_src_gap();
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Monitor: check each output transfer, then choose tready for the next
	// cycle. A requested hold keeps tready low until its LONG_HOLD countdown runs out.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready)
				check_lines(i2cm_pkg::res_t'(m_tdata[13:0]));
			if (hold_served != hold_reqs) begin
				hold_served++;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (!sink_stall_on) begin
				m_tready <= 1'b1;
			end else if (sink_stall_left > 0) begin
				sink_stall_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
				sink_stall_left = pick_sink_stall();
			end
		end
	end

	// Queue one tick and step the planning copy; ticks the sequencer ignores
	// (no command, or a reserved opcode, while idle) are not counted.
	task automatic push_tick(input i2cm_pkg::item_t it);
		while (ticks_to_send.size() >= QUEUE_DEPTH)
			@(negedge clk);
		if (plan_seq.phase != i2cm_pkg::PH_IDLE ||
				(it.cmd_valid && it.opcode <= i2cm_pkg::OP_ACK_ONLY))
			n_items++;
		ticks_to_send.push_back(it);
		void'(bus_tick(plan_seq, it));
	endtask

	// One tick with no new command while idle; while busy, sometimes a command
	// that must be ignored. During ack polling drive SDA low once the chosen
	// number of high polls has passed.
	task automatic fill_tick();
		i2cm_pkg::item_t it;
		it.cmd_valid = (plan_seq.phase != i2cm_pkg::PH_IDLE) && ($urandom_range(0, 9) == 0);
		it.opcode = 3'($urandom_range(0, 7));
		it.write_data = 8'($urandom);
		it.send_ack = 1'($urandom);
		if (plan_seq.phase == i2cm_pkg::PH_ACK_POLL) begin
			it.sda_sample = !(ack_delay != ACK_NEVER && polls >= ack_delay);
			polls++;
		end else if (sda_force != SDA_FREE) begin
			it.sda_sample = sda_force[0];
		end else begin
			it.sda_sample = 1'($urandom);
		end
		push_tick(it);
	endtask

	// Queue ticks until the running command is over.
	task automatic run_out();
		while (plan_seq.phase != i2cm_pkg::PH_IDLE)
			fill_tick();
	endtask

	// Let the current command run out, maybe idle a little, then issue a new one.
	task automatic issue(input logic [2:0] op, input logic [7:0] data, input logic ack,
			input int ack_wait);
		i2cm_pkg::item_t it;
		run_out();
		if ($urandom_range(0, 4) == 0)
			repeat ($urandom_range(1, 3)) fill_tick();
		ack_delay = ack_wait;
		polls = 0;
		it.cmd_valid = 1'b1;
		it.opcode = op;
		it.write_data = data;
		it.send_ack = ack;
		it.sda_sample = 1'($urandom);
		push_tick(it);
	endtask

	task automatic wait_drained();
		while (ticks_to_send.size() != 0 || s_tvalid || line_states_due.size() != 0)
			@(negedge clk);
	endtask

	// Finish the running command, drain both streams, then write one register.
	task automatic write_reg(input i2cm_pkg::cfg_idx_t idx, input logic [15:0] v);
		run_out();
		wait_drained();
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		set_cfg(plan_seq, idx, v);
		set_cfg(live_seq, idx, v);
	endtask

	// Mostly an ack within a few polls, sometimes none so the timeout fires.
	function automatic int pick_ack();
		int lim;
		lim = (plan_seq.timeout_cfg < 8'd4) ? int'(plan_seq.timeout_cfg) : 4;
		if ($urandom_range(0, 9) < 3)
			return ACK_NEVER;
		return $urandom_range(0, lim);
	endfunction

	// A well-formed bus transaction: start, address, ack, a few data bytes, stop.
	task automatic run_transaction();
		int n;
		n = $urandom_range(1, 3);
		issue(i2cm_pkg::OP_START, 8'($urandom), 1'($urandom), ACK_NEVER);
		issue(i2cm_pkg::OP_WRITE, 8'($urandom), 1'($urandom), ACK_NEVER);
		issue(i2cm_pkg::OP_WAIT_ACK, 8'($urandom), 1'($urandom), pick_ack());
		repeat (n) begin
			if ($urandom_range(0, 1)) begin
				issue(i2cm_pkg::OP_WRITE, 8'($urandom), 1'($urandom), ACK_NEVER);
				issue(i2cm_pkg::OP_WAIT_ACK, 8'($urandom), 1'($urandom), pick_ack());
			end else begin
				issue(i2cm_pkg::OP_READ, 8'($urandom), 1'($urandom), ACK_NEVER);
			end
		end
		issue(i2cm_pkg::OP_STOP, 8'($urandom), 1'($urandom), ACK_NEVER);
	endtask

	initial begin
		int next_retune;
		plan_seq = fresh_model();
		live_seq = fresh_model();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// reset phase delay: a start at 200 ticks per phase
		issue(i2cm_pkg::OP_START, 8'h00, 1'b0, ACK_NEVER);
		// reset ack timeout: an ack that never comes, at short phases
		write_reg(i2cm_pkg::CFG_PHASE_DELAY, 16'd1);
		issue(i2cm_pkg::OP_WAIT_ACK, 8'h00, 1'b0, ACK_NEVER);

		// directed commands at short phases
		write_reg(i2cm_pkg::CFG_ACK_TIMEOUT, 16'd3);
		src_gap_on = 1'b1;
		sink_stall_on = 1'b1;
		issue(i2cm_pkg::OP_START, 8'h00, 1'b1, ACK_NEVER);
		issue(i2cm_pkg::OP_WRITE, 8'hFF, 1'b0, ACK_NEVER);
		issue(i2cm_pkg::OP_WAIT_ACK, 8'h00, 1'b0, 0);
		issue(i2cm_pkg::OP_WRITE, 8'h00, 1'b1, ACK_NEVER);
		issue(i2cm_pkg::OP_WAIT_ACK, 8'hFF, 1'b1, 2);
		issue(i2cm_pkg::OP_WRITE, 8'hA5, 1'b0, ACK_NEVER);
		// ack never comes: stop follows, flag holds through the next start
		issue(i2cm_pkg::OP_WAIT_ACK, 8'h00, 1'b0, ACK_NEVER);
		issue(i2cm_pkg::OP_START, 8'h00, 1'b0, ACK_NEVER);
		sda_force = 1;
		issue(i2cm_pkg::OP_READ, 8'h00, 1'b1, ACK_NEVER);
		run_out();
		sda_force = 0;
		issue(i2cm_pkg::OP_READ, 8'hFF, 1'b0, ACK_NEVER);
		run_out();
		sda_force = SDA_FREE;
		issue(i2cm_pkg::OP_READ, 8'h5A, 1'b1, ACK_NEVER);
		issue(i2cm_pkg::OP_ACK_ONLY, 8'h00, 1'b1, ACK_NEVER);
		issue(i2cm_pkg::OP_ACK_ONLY, 8'hFF, 1'b0, ACK_NEVER);
		// ack on the last poll before the timeout
		issue(i2cm_pkg::OP_WAIT_ACK, 8'h00, 1'b0, 3);
		issue(i2cm_pkg::OP_STOP, 8'h00, 1'b0, ACK_NEVER);
		issue(OP_RSVD_6, 8'hFF, 1'b1, ACK_NEVER);
		issue(OP_RSVD_7, 8'h00, 1'b0, ACK_NEVER);

		// zero phase delay and zero ack timeout
		write_reg(i2cm_pkg::CFG_PHASE_DELAY, 16'd0);
		write_reg(i2cm_pkg::CFG_ACK_TIMEOUT, 16'd0);
		issue(i2cm_pkg::OP_START, 8'h00, 1'b0, ACK_NEVER);
		issue(i2cm_pkg::OP_WAIT_ACK, 8'h00, 1'b0, ACK_NEVER);
		issue(i2cm_pkg::OP_WAIT_ACK, 8'h00, 1'b0, 0);
		issue(i2cm_pkg::OP_STOP, 8'h00, 1'b0, ACK_NEVER);

		// stall the result side for a long stretch while ticks keep coming
		write_reg(i2cm_pkg::CFG_PHASE_DELAY, 16'd1);
		write_reg(i2cm_pkg::CFG_ACK_TIMEOUT, 16'd5);
		src_gap_on = 1'b0;
		hold_reqs++;
		run_transaction();
		src_gap_on = 1'b1;

		// random part: mostly transactions, some lone commands, retune now and then
		n_items = 0;
		next_retune = RETUNE_EVERY;
		while (n_items < RANDOM_TICKS) begin
			if (n_items >= next_retune) begin
				write_reg(i2cm_pkg::CFG_PHASE_DELAY, 16'(($urandom_range(0, 9) < 7) ?
					$urandom_range(1, 2) : $urandom_range(3, 6)));
				write_reg(i2cm_pkg::CFG_ACK_TIMEOUT, 16'($urandom_range(0, 6)));
				src_gap_on = ($urandom_range(0, 3) != 0);
				sink_stall_on = ($urandom_range(0, 3) != 0);
				next_retune = n_items + RETUNE_EVERY;
			end
			if ($urandom_range(0, 4) != 0)
				run_transaction();
			else
				issue(3'($urandom_range(0, 7)), 8'($urandom), 1'($urandom), pick_ack());
		end

		// largest ack timeout, then an ack timeout of 1, no idling on either side
		src_gap_on = 1'b0;
		sink_stall_on = 1'b0;
		write_reg(i2cm_pkg::CFG_PHASE_DELAY, 16'd1);
		write_reg(i2cm_pkg::CFG_ACK_TIMEOUT, ACK_TIMEOUT_MAX);
		issue(i2cm_pkg::OP_WAIT_ACK, 8'h00, 1'b0, 4);
		write_reg(i2cm_pkg::CFG_ACK_TIMEOUT, 16'd1);
		issue(i2cm_pkg::OP_WAIT_ACK, 8'h00, 1'b0, 1);
		run_out();

		wait_drained();
		repeat (4) @(posedge clk);
		if (n_errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

### sim.f
src/i2cm_pkg.sv
src/i2cm_seq.sv
src/i2c_master_bit_sequencer_top.sv
dv/tb.sv
